// ----- design/sbag_pkg.sv -----
// ----------------------------------------------------------------------------
// sbag_pkg
// Shared types and constants for the sprite blit address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbag_pkg;

  // Item kinds on the input channel
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_PIXEL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_DRAW_MODE        = 2'd0;
  localparam logic [1:0] CFG_SCREEN_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_SCREEN_HEIGHT    = 2'd2;
  localparam logic [1:0] CFG_PLANE_BLOCK_SIZE = 2'd3;

  // Draw modes; bit 1 set selects the stacked planar buffer
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_PLANAR = 2'd1;

  // Reset values of the configuration registers
  localparam logic [1:0]  RST_DRAW_MODE        = MODE_LINEAR;
  localparam logic [10:0] RST_SCREEN_WIDTH     = 11'd320;
  localparam logic [10:0] RST_SCREEN_HEIGHT    = 11'd200;
  localparam logic [18:0] RST_PLANE_BLOCK_SIZE = 19'd16000;

  localparam int ADDR_W = 20;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]  draw_mode;
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [18:0] plane_block_size;
  } cfg_t;

  // One pixel on its way to the address stage
  typedef struct packed {
    logic        we;
    logic [10:0] ux;
    logic [10:0] uy;
    logic [7:0]  pix;
    logic        last;
  } job_t;

endpackage

`default_nettype wire

// ----- design/sbag_tracker.sv -----
// ----------------------------------------------------------------------------
// sbag_tracker
// Header clamp, blit state and raster counters; registers one pixel job.
// ----------------------------------------------------------------------------
`default_nettype none

module sbag_tracker import sbag_pkg::*; #(
  parameter int MAX_DIMENSION = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic signed [11:0] pos_x,
  input  wire logic signed [11:0] pos_y,
  input  wire logic [10:0]        width,
  input  wire logic [10:0]        height,
  input  wire logic               transparent,
  input  wire logic [7:0]         pixel,
  output logic                    job_valid,
  output job_t                    job,
  input  wire logic               job_ready
);

  localparam int DimW = ($clog2(MAX_DIMENSION + 1) > 11) ? $clog2(MAX_DIMENSION + 1) : 11;

  // Blit state
  logic signed [11:0] origin_x, origin_y;
  logic [10:0]        blit_width, blit_height;
  logic               key_enabled, on_screen;
  logic [10:0]        column_count, row_count;

  logic accept;
  assign in_ready = !job_valid || job_ready;
  assign accept   = in_valid && in_ready;

  // Header: saturate size, reject, clamp origin
  logic [10:0]        w_sat, h_sat;
  logic signed [13:0] xs, ys, wi, hi, swi, shi, x1, y1, x2, y2;
  logic               reject;

  always_comb begin
    w_sat = (DimW'(width) > DimW'(MAX_DIMENSION)) ? 11'(MAX_DIMENSION) : width;
    h_sat = (DimW'(height) > DimW'(MAX_DIMENSION)) ? 11'(MAX_DIMENSION) : height;
    xs  = 14'(pos_x);
    ys  = 14'(pos_y);
    wi  = $signed({3'b000, w_sat});
    hi  = $signed({3'b000, h_sat});
    swi = $signed({3'b000, cfg.screen_width});
    shi = $signed({3'b000, cfg.screen_height});
    reject = (w_sat == 11'd0) || (h_sat == 11'd0) ||
             (xs >= swi) || (xs + wi <= 14'sd0) ||
             (ys >= shi) || (ys + hi <= 14'sd0);
    x1 = (xs < 14'sd0) ? 14'sd0 : xs;
    y1 = (ys < 14'sd0) ? 14'sd0 : ys;
    x2 = (x1 + wi > swi) ? swi - wi : x1;
    y2 = (y1 + hi > shi) ? shi - hi : y1;
  end

  // Pixel: position, visibility, end of bitmap
  logic signed [13:0] px, py;
  logic               visible, last_pix, row_end;
  logic [11:0]        col_inc, row_inc;

  always_comb begin
    px = 14'(origin_x) + $signed({3'b000, column_count});
    py = 14'(origin_y) + $signed({3'b000, row_count});
    visible = !px[13] && (px[12:0] < {2'b00, cfg.screen_width}) &&
              !py[13] && (py[12:0] < {2'b00, cfg.screen_height});
    col_inc  = {1'b0, column_count} + 12'd1;
    row_inc  = {1'b0, row_count} + 12'd1;
    row_end  = col_inc >= {1'b0, blit_width};
    last_pix = (col_inc == {1'b0, blit_width}) && (row_inc == {1'b0, blit_height});
  end

  // State update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      blit_width   <= 11'd1;
      blit_height  <= 11'd1;
      key_enabled  <= 1'b0;
      on_screen    <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (func == FUNC_HEADER) begin
        column_count <= '0;
        row_count    <= '0;
        key_enabled  <= transparent;
        on_screen    <= !reject;
        if (!reject) begin
          origin_x    <= x2[11:0];
          origin_y    <= y2[11:0];
          blit_width  <= w_sat;
          blit_height <= h_sat;
        end
      end else if (on_screen) begin
        if (last_pix) begin
          on_screen    <= 1'b0;
          column_count <= '0;
          row_count    <= '0;
        end else if (row_end) begin
          column_count <= '0;
          row_count    <= row_inc[10:0];
        end else begin
          column_count <= col_inc[10:0];
        end
      end
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= accept && (func == FUNC_PIXEL) && on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.we   <= visible && !(key_enabled && (pixel == 8'd0));
      job.ux   <= px[10:0];
      job.uy   <= py[10:0];
      job.pix  <= pixel;
      job.last <= last_pix;
    end
  end

endmodule

`default_nettype wire

// ----- design/sbag_addr_unit.sv -----
// ----------------------------------------------------------------------------
// sbag_addr_unit
// Framebuffer address, data and plane mask for one pixel; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbag_addr_unit import sbag_pkg::*; #(
  parameter int LINEAR_STRIDE = 320
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       job_valid,
  input  wire job_t       job,
  output logic            job_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            write_enable,
  output logic [ADDR_W-1:0] write_addr,
  output logic [7:0]      write_data,
  output logic [3:0]      plane_mask,
  output logic            last
);

  logic              linear, planar, stacked;
  logic [ADDR_W-1:0] factor, addend, prod, plane_off, addr;
  logic [ADDR_W-1:0] pbs;

  assign job_ready = !out_valid || out_ready;

  // One shared multiplier: row times stride or planar pitch
  always_comb begin
    linear  = (cfg.draw_mode == MODE_LINEAR);
    planar  = (cfg.draw_mode == MODE_PLANAR);
    stacked = cfg.draw_mode[1];
    pbs     = ADDR_W'(cfg.plane_block_size);
    factor  = linear ? ADDR_W'(LINEAR_STRIDE) : ADDR_W'(cfg.screen_width[10:2]);
    addend  = linear ? ADDR_W'(job.ux) : ADDR_W'(job.ux[10:2]);
    prod    = ADDR_W'(job.uy) * factor;
    plane_off = '0;
    if (stacked) begin
      plane_off = (job.ux[0] ? pbs : '0) + (job.ux[1] ? {pbs[ADDR_W-2:0], 1'b0} : '0);
    end
    addr = prod + addend + plane_off;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_ready) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      write_enable <= job.we;
      write_addr   <= job.we ? addr : '0;
      write_data   <= job.we ? job.pix : 8'd0;
      plane_mask   <= (job.we && planar) ? (4'b0001 << job.ux[1:0]) : 4'b0000;
      last         <= job.last;
    end
  end

endmodule

`default_nettype wire

// ----- design/sprite_blit_address_generator.sv -----
// Sprite blit address generator. A header transfer (func 0) sets position,
// size and color key of a bitmap and yields no result; each pixel transfer
// (func 1) of an active bitmap yields one result with the framebuffer byte
// address, data and plane mask. The block takes one item per clock while
// out_ready holds, and registers each result twice: first in the job register
// behind the raster counters, then in the output register behind the single
// address multiplier. Configuration writes are taken at any time
// (cfg_ready is always high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
// sprite_blit_address_generator
// Top level: configuration registers, counter stage and address stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_address_generator import sbag_pkg::*; #(
  parameter int MAX_DIMENSION = 1024,
  parameter int LINEAR_STRIDE = 320
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [18:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic signed [11:0] pos_x,
  input  wire logic signed [11:0] pos_y,
  input  wire logic [10:0]        width,
  input  wire logic [10:0]        height,
  input  wire logic               transparent,
  input  wire logic [7:0]         pixel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    write_enable,
  output logic [ADDR_W-1:0]       write_addr,
  output logic [7:0]              write_data,
  output logic [3:0]              plane_mask,
  output logic                    last
);

  cfg_t cfg;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.draw_mode        <= RST_DRAW_MODE;
      cfg.screen_width     <= RST_SCREEN_WIDTH;
      cfg.screen_height    <= RST_SCREEN_HEIGHT;
      cfg.plane_block_size <= RST_PLANE_BLOCK_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRAW_MODE:        cfg.draw_mode        <= cfg_data[1:0];
        CFG_SCREEN_WIDTH:     cfg.screen_width     <= cfg_data[10:0];
        CFG_SCREEN_HEIGHT:    cfg.screen_height    <= cfg_data[10:0];
        CFG_PLANE_BLOCK_SIZE: cfg.plane_block_size <= cfg_data;
        default: ;
      endcase
    end
  end

  sbag_tracker #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width       (width),
    .height      (height),
    .transparent (transparent),
    .pixel       (pixel),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready)
  );

  sbag_addr_unit #(
    .LINEAR_STRIDE(LINEAR_STRIDE)
  ) u_addr (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .write_addr   (write_addr),
    .write_data   (write_data),
    .plane_mask   (plane_mask),
    .last         (last)
  );

  // A skipped pixel carries zero address, data and mask
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_addr == '0 && write_data == 8'd0 &&
                                   plane_mask == 4'd0)
    else $error("skipped pixel with nonzero payload");

  // A plane mask only goes with a written pixel and selects one plane
  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && plane_mask != 4'd0 |-> write_enable && $onehot(plane_mask))
    else $error("bad plane mask");

  // A header transfer never produces a pixel job
  a_header_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_HEADER |=> !job_valid)
    else $error("header produced a job");

endmodule

`default_nettype wire
